### hw/rtl/smpq_pkg.sv
// Shared types, codes and defaults for the stable max priority queue.
`default_nettype none
package smpq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CODE_W  = 16;
  localparam int AGE_W   = 8;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [AGE_W-1:0]  age;
  } entry_t;

endpackage
`default_nettype wire

### hw/rtl/stable_max_priority_queue_core.sv
// Top level of the stable max priority queue: sorted store, sequencer and output register.
//
//   channel | direction | handshake           | payload
//   in_     | slave     | in_tvalid/in_tready | tdata: code, age; tuser: req_type
//   out_    | master    | out_tvalid/out_tready | tdata: removed, head, count; tuser: status
//
// Insert: entries of smaller age are read from the tail and moved down one slot, then the new entry is written.
// Remove shifts every entry behind the head up one slot; rejected or empty requests only read the head.
// One memory read port and one write port set the pace; each moved slot costs a read and a write.
// Reset clears the count, the sequencer and the output valid flag; slot contents stay undefined until written.
// A result waits in the output register while the next item is accepted; the sequencer
// holds before loading a new result until the previous one is taken.
`default_nettype none
module stable_max_priority_queue_core #(
  parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] entry_code, [23:16] entry_age
  input  wire logic [smpq_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] req_type
  input  wire logic [0:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] removed_code, [23:16] removed_age, [24] head_valid, [40:25] head_code,
  // [48:41] head_age, [53:49] entry_count, [55:54] zero
  output logic [smpq_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [1:0] status
  output logic [smpq_pkg::STAT_W-1:0]           out_tuser
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_REM_RD  = 3'd4;
  localparam logic [2:0] S_REM_MOV = 3'd5;
  localparam logic [2:0] S_HEAD_RD = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  smpq_pkg::entry_t mem [DEPTH];

  logic [2:0]                    state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  smpq_pkg::entry_t              new_r, new_nxt;
  smpq_pkg::entry_t              rem_r, rem_nxt;
  logic [smpq_pkg::STAT_W-1:0]   stat_r, stat_nxt;
  smpq_pkg::entry_t              rd_data_r;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  smpq_pkg::entry_t              wr_data;
  logic                          out_valid_r, out_valid_nxt;
  logic [smpq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [smpq_pkg::STAT_W-1:0]   out_user_r, out_user_nxt;
  logic                          in_acc;
  logic                          out_load;
  logic [CW-1:0]                 idx_inc;
  logic [CW+4:0]                 count_wide;
  smpq_pkg::entry_t              head;
  logic                          head_vld;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign idx_inc    = CW'(idx_r) + CW'(1);
  assign count_wide = {5'd0, count_r};
  assign head_vld   = (count_r != '0);
  assign head       = head_vld ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    new_nxt   = new_r;
    rem_nxt   = rem_r;
    stat_nxt  = stat_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = new_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt.code = in_tdata[15:0];
          new_nxt.age  = in_tdata[23:16];
          rem_nxt      = '0;
          stat_nxt     = smpq_pkg::STAT_OK;
          idx_nxt      = '0;
          if (in_tuser[0] == smpq_pkg::REQ_INSERT) begin
            if (count_r >= CW'(DEPTH)) begin
              stat_nxt  = smpq_pkg::STAT_FULL;
              state_nxt = S_HEAD_RD;
            end else begin
              idx_nxt   = AW'(count_r);
              state_nxt = (count_r == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              stat_nxt  = smpq_pkg::STAT_EMPTY;
              state_nxt = S_HEAD_RD;
            end else begin
              state_nxt = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        rd_addr   = idx_r - AW'(1);
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rd_data_r.age < new_r.age) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_r;
          idx_nxt   = idx_r - AW'(1);
          state_nxt = (idx_r == AW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_data   = new_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_HEAD_RD;
      end
      S_REM_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_REM_MOV;
      end
      S_REM_MOV: begin
        if (idx_r == '0) begin
          rem_nxt = rd_data_r;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r - AW'(1);
          wr_data = rd_data_r;
        end
        if (idx_inc < count_r) begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_REM_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = stat_r;
      out_data_nxt  = {2'b00, count_wide[4:0], head.age, head.code, head_vld,
                       rem_r.age, rem_r.code};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    new_r      <= new_nxt;
    rem_r      <= rem_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INS_PUT && state_r != S_REM_MOV) |=> $stable(count_r))
    else $error("count changed outside insert or remove");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && stat_r == smpq_pkg::STAT_FULL) |-> count_r == CW'(DEPTH))
    else $error("full status with free slots");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && stat_r == smpq_pkg::STAT_EMPTY) |=> !out_tdata[24])
    else $error("empty status with a valid head");

  a_ins_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_RD) |-> (idx_r != '0 && CW'(idx_r) <= count_r))
    else $error("insert scan index out of range");

endmodule
`default_nettype wire
